### rtl/vbi_pkg.sv
// ----------------------------------------------------------------------------
// vbi_pkg: shared types and constants for the Verlet body integrator
// Lane and merger FSM states, lane/merger status bundles, register indexes
// and the fixed field widths of the block.
// ----------------------------------------------------------------------------
`default_nettype none

package vbi_pkg;

   // Fixed field widths
   localparam int STEP_WIDTH      = 32;  // time_step and pixel_scale
   localparam int SCALE_FRAC      = 24;  // pixel_scale is Q8.24
   localparam int SCREEN_WIDTH    = 16;  // pixel coordinates
   localparam int CSR_INDEX_WIDTH = 3;

   // Configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TIME_STEP   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_POS_X = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_POS_Y = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_VEL_X = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_VEL_Y = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PIXEL_SCALE = 3'd5;

   // Per-axis lane sequencer
   typedef enum logic [3:0] {
      L_IDLE,
      L_DV_MUL,
      L_DV,
      L_VEL,
      L_BACK_LD,
      L_BACK_MUL,
      L_BACK,
      L_PREV,
      L_TERM_MUL,
      L_TERM,
      L_POS,
      L_SCR_LD,
      L_SCR_MUL,
      L_SCR,
      L_SQ_MUL,
      L_DONE
   } lane_state_type;

   // Merger sequencer
   typedef enum logic [1:0] {
      M_IDLE,
      M_ROOT,
      M_DONE
   } merge_state_type;

   // Top to lanes: start one step
   typedef struct packed {
      logic start;
      logic seed;
   } lane_ctrl_type;

   // Lane to merger: step finished, saturation seen
   typedef struct packed {
      logic done;
      logic ovf;
   } lane_status_type;

   // Merger to top: result ready, combined saturation flag
   typedef struct packed {
      logic done;
      logic ovf;
   } merge_status_type;

endpackage

`default_nettype wire

### rtl/vbi_lane.sv
// ----------------------------------------------------------------------------
// vbi_lane: one axis of the integrator
// Holds pos/prev/vel for its axis and runs the step through a shared
// shift-add multiplier: a*dt, seed v*dt, (a*dt)*dt, pos*scale and |v|^2.
// ----------------------------------------------------------------------------
`default_nettype none

module vbi_lane
   import vbi_pkg::*;
#(
   parameter int WORD_WIDTH = 48,
   parameter int FRAC_BITS  = 16
)
(
   input  logic                           clock,
   input  logic                           reset,
   input  lane_ctrl_type                  ctrl,
   input  logic                           ack,
   input  logic signed [WORD_WIDTH-1:0]   acc,
   input  logic signed [WORD_WIDTH-1:0]   start_pos,
   input  logic signed [WORD_WIDTH-1:0]   start_vel,
   input  logic        [STEP_WIDTH-1:0]   time_step,
   input  logic        [STEP_WIDTH-1:0]   pixel_scale,
   output logic signed [WORD_WIDTH-1:0]   pos,
   output logic signed [SCREEN_WIDTH-1:0] screen,
   output logic        [2*WORD_WIDTH-1:0] vsq,
   output lane_status_type                status
);

   localparam int PW        = 2 * WORD_WIDTH;
   localparam int SW        = WORD_WIDTH + 3;
   localparam int SCR_SHIFT = FRAC_BITS + SCALE_FRAC;

   localparam logic [PW-1:0] W_LIM = PW'(1) << (WORD_WIDTH - 1);
   localparam logic [PW-1:0] S_LIM = PW'(1) << (SCREEN_WIDTH - 1);
   localparam logic signed [WORD_WIDTH-1:0] W_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
   localparam logic signed [WORD_WIDTH-1:0] W_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};
   localparam logic signed [SCREEN_WIDTH-1:0] S_MAX = {1'b0, {(SCREEN_WIDTH-1){1'b1}}};
   localparam logic signed [SCREEN_WIDTH-1:0] S_MIN = {1'b1, {(SCREEN_WIDTH-1){1'b0}}};

   // Magnitude of a signed word
   function automatic logic [WORD_WIDTH-1:0] mag_of(input logic signed [WORD_WIDTH-1:0] v);
      logic signed [WORD_WIDTH-1:0] n;
      n = -v;
      return v[WORD_WIDTH-1] ? n : v;
   endfunction

   // Clamp an exact sum to the word; top bit is the saturation flag
   function automatic logic [WORD_WIDTH:0] sat_sum(input logic signed [SW-1:0] v);
      logic [SW-WORD_WIDTH:0] top_bits;
      top_bits = v[SW-1:WORD_WIDTH-1];
      if ((&top_bits) || !(|top_bits)) begin
         return {1'b0, v[WORD_WIDTH-1:0]};
      end else if (v[SW-1]) begin
         return {1'b1, W_MIN};
      end else begin
         return {1'b1, W_MAX};
      end
   endfunction

   lane_state_type state_ff, state_in;

   logic signed [WORD_WIDTH-1:0]   pos_ff, pos_in;
   logic signed [WORD_WIDTH-1:0]   prev_ff, prev_in;
   logic signed [WORD_WIDTH-1:0]   vel_ff, vel_in;
   logic signed [WORD_WIDTH-1:0]   dv_ff, dv_in;
   logic signed [WORD_WIDTH-1:0]   tmp_ff, tmp_in;
   logic signed [SCREEN_WIDTH-1:0] scr_ff, scr_in;
   logic                           ovf_ff, ovf_in;
   logic                           seed_ff, seed_in;
   logic                           neg_ff, neg_in;
   logic [PW-1:0]                  mcand_ff, mcand_in;
   logic [WORD_WIDTH-1:0]          mplier_ff, mplier_in;
   logic [PW-1:0]                  prod_ff, prod_in;

   logic                           mul_done;
   logic [PW-1:0]                  mw_mag;
   logic                           mw_ovf;
   logic signed [WORD_WIDTH-1:0]   mw_val;
   logic [PW-1:0]                  ms_mag;
   logic                           ms_ovf;
   logic signed [SCREEN_WIDTH-1:0] ms_val;
   logic [WORD_WIDTH:0]            vel_sum;
   logic [WORD_WIDTH:0]            prev_sum;
   logic [WORD_WIDTH:0]            pos_sum;

   assign mul_done = (mplier_ff == '0);

   // Product to word: truncate magnitude, restore sign, clamp
   always_comb begin
      mw_mag = prod_ff >> FRAC_BITS;
      mw_ovf = neg_ff ? (mw_mag > W_LIM) : (mw_mag >= W_LIM);
      if (mw_ovf) begin
         mw_val = neg_ff ? W_MIN : W_MAX;
      end else if (neg_ff) begin
         mw_val = -$signed(mw_mag[WORD_WIDTH-1:0]);
      end else begin
         mw_val = $signed(mw_mag[WORD_WIDTH-1:0]);
      end
   end

   // Product to pixels
   always_comb begin
      ms_mag = prod_ff >> SCR_SHIFT;
      ms_ovf = neg_ff ? (ms_mag > S_LIM) : (ms_mag >= S_LIM);
      if (ms_ovf) begin
         ms_val = neg_ff ? S_MIN : S_MAX;
      end else if (neg_ff) begin
         ms_val = -$signed(ms_mag[SCREEN_WIDTH-1:0]);
      end else begin
         ms_val = $signed(ms_mag[SCREEN_WIDTH-1:0]);
      end
   end

   // Exact sums, clamped once
   assign vel_sum  = sat_sum(SW'(vel_ff) + SW'(dv_ff));
   assign prev_sum = sat_sum(SW'(pos_ff) - SW'(tmp_ff));
   assign pos_sum  = sat_sum(SW'(pos_ff) + SW'(pos_ff) - SW'(prev_ff) + SW'(tmp_ff));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         L_IDLE:     if (ctrl.start) state_in = L_DV_MUL;
         L_DV_MUL:   if (mul_done) state_in = L_DV;
         L_DV:       state_in = L_VEL;
         L_VEL:      state_in = seed_ff ? L_BACK_LD : L_TERM_MUL;
         L_BACK_LD:  state_in = L_BACK_MUL;
         L_BACK_MUL: if (mul_done) state_in = L_BACK;
         L_BACK:     state_in = L_PREV;
         L_PREV:     state_in = L_TERM_MUL;
         L_TERM_MUL: if (mul_done) state_in = L_TERM;
         L_TERM:     state_in = L_POS;
         L_POS:      state_in = L_SCR_LD;
         L_SCR_LD:   state_in = L_SCR_MUL;
         L_SCR_MUL:  if (mul_done) state_in = L_SCR;
         L_SCR:      state_in = L_SQ_MUL;
         L_SQ_MUL:   if (mul_done) state_in = L_DONE;
         L_DONE:     if (ack) state_in = L_IDLE;
         default:    state_in = L_IDLE;
      endcase
   end

   // Datapath per state
   always_comb begin
      pos_in    = pos_ff;
      prev_in   = prev_ff;
      vel_in    = vel_ff;
      dv_in     = dv_ff;
      tmp_in    = tmp_ff;
      scr_in    = scr_ff;
      ovf_in    = ovf_ff;
      seed_in   = seed_ff;
      neg_in    = neg_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      prod_in   = prod_ff;
      case (state_ff)
         L_IDLE: begin
            if (ctrl.start) begin
               seed_in   = ctrl.seed;
               ovf_in    = 1'b0;
               if (ctrl.seed) begin
                  pos_in = start_pos;
                  vel_in = start_vel;
               end
               mcand_in  = PW'(mag_of(acc));
               mplier_in = WORD_WIDTH'(time_step);
               prod_in   = '0;
               neg_in    = acc[WORD_WIDTH-1];
            end
         end
         L_DV_MUL, L_BACK_MUL, L_TERM_MUL, L_SCR_MUL, L_SQ_MUL: begin
            if (!mul_done) begin
               prod_in   = mplier_ff[0] ? prod_ff + mcand_ff : prod_ff;
               mcand_in  = mcand_ff << 1;
               mplier_in = mplier_ff >> 1;
            end
         end
         L_DV: begin
            dv_in  = mw_val;
            ovf_in = ovf_ff | mw_ovf;
         end
         L_VEL: begin
            vel_in = $signed(vel_sum[WORD_WIDTH-1:0]);
            ovf_in = ovf_ff | vel_sum[WORD_WIDTH];
            if (!seed_ff) begin
               mcand_in  = PW'(mag_of(dv_ff));
               mplier_in = WORD_WIDTH'(time_step);
               prod_in   = '0;
               neg_in    = dv_ff[WORD_WIDTH-1];
            end
         end
         L_BACK_LD: begin
            mcand_in  = PW'(mag_of(vel_ff));
            mplier_in = WORD_WIDTH'(time_step);
            prod_in   = '0;
            neg_in    = vel_ff[WORD_WIDTH-1];
         end
         L_BACK, L_TERM: begin
            tmp_in = mw_val;
            ovf_in = ovf_ff | mw_ovf;
         end
         L_PREV: begin
            prev_in   = $signed(prev_sum[WORD_WIDTH-1:0]);
            ovf_in    = ovf_ff | prev_sum[WORD_WIDTH];
            mcand_in  = PW'(mag_of(dv_ff));
            mplier_in = WORD_WIDTH'(time_step);
            prod_in   = '0;
            neg_in    = dv_ff[WORD_WIDTH-1];
         end
         L_POS: begin
            prev_in = pos_ff;
            pos_in  = $signed(pos_sum[WORD_WIDTH-1:0]);
            ovf_in  = ovf_ff | pos_sum[WORD_WIDTH];
         end
         L_SCR_LD: begin
            mcand_in  = PW'(mag_of(pos_ff));
            mplier_in = WORD_WIDTH'(pixel_scale);
            prod_in   = '0;
            neg_in    = pos_ff[WORD_WIDTH-1];
         end
         L_SCR: begin
            scr_in    = ms_val;
            ovf_in    = ovf_ff | ms_ovf;
            mcand_in  = PW'(mag_of(vel_ff));
            mplier_in = mag_of(vel_ff);
            prod_in   = '0;
            neg_in    = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         pos_ff   <= '0;
         prev_ff  <= '0;
         vel_ff   <= '0;
         ovf_ff   <= 1'b0;
         seed_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         prev_ff  <= prev_in;
         vel_ff   <= vel_in;
         ovf_ff   <= ovf_in;
         seed_ff  <= seed_in;
      end
      dv_ff     <= dv_in;
      tmp_ff    <= tmp_in;
      scr_ff    <= scr_in;
      neg_ff    <= neg_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      prod_ff   <= prod_in;
   end

   assign pos         = pos_ff;
   assign screen      = scr_ff;
   assign vsq         = prod_ff;
   assign status.done = (state_ff == L_DONE);
   assign status.ovf  = ovf_ff;

endmodule

`default_nettype wire

### rtl/vbi_merge.sv
// ----------------------------------------------------------------------------
// vbi_merge: combines the two lanes
// Adds the squared velocity components, takes the floor square root one
// result bit per cycle and merges the saturation flags.
// ----------------------------------------------------------------------------
`default_nettype none

module vbi_merge
   import vbi_pkg::*;
#(
   parameter int WORD_WIDTH = 48
)
(
   input  logic                           clock,
   input  logic                           reset,
   input  lane_status_type                lane_x,
   input  lane_status_type                lane_y,
   input  logic        [2*WORD_WIDTH-1:0] vsq_x,
   input  logic        [2*WORD_WIDTH-1:0] vsq_y,
   input  logic                           out_free,
   output logic                           lane_ack,
   output logic        [WORD_WIDTH-1:0]   speed,
   output merge_status_type               status
);

   localparam int PW = 2 * WORD_WIDTH;
   localparam int RW = WORD_WIDTH + 2;
   localparam int TW = WORD_WIDTH + 4;
   localparam int CW = $clog2(WORD_WIDTH);

   merge_state_type state_ff, state_in;

   logic [PW-1:0]         rad_ff, rad_in;
   logic [RW-1:0]         rem_ff, rem_in;
   logic [WORD_WIDTH-1:0] root_ff, root_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  ovf_ff, ovf_in;

   logic                  both_done;
   logic [PW:0]           sq_sum;
   logic [TW-1:0]         rem_try;
   logic [TW-1:0]         root_try;
   logic [TW-1:0]         rem_diff;

   assign both_done = lane_x.done && lane_y.done;
   // Sum of squares never exceeds 2^(2W-1), so the carry bit is always zero
   assign sq_sum    = {1'b0, vsq_x} + {1'b0, vsq_y};
   assign rem_try   = {rem_ff, rad_ff[PW-1:PW-2]};
   assign root_try  = {2'b00, root_ff, 2'b01};
   assign rem_diff  = rem_try - root_try;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         M_IDLE:  if (both_done) state_in = M_ROOT;
         M_ROOT:  if (cnt_ff == '0) state_in = M_DONE;
         M_DONE:  if (out_free) state_in = M_IDLE;
         default: state_in = M_IDLE;
      endcase
   end

   // Square root datapath: one result bit per cycle
   always_comb begin
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      cnt_in   = cnt_ff;
      ovf_in   = ovf_ff;
      lane_ack = 1'b0;
      case (state_ff)
         M_IDLE: begin
            if (both_done) begin
               lane_ack = 1'b1;
               rad_in   = sq_sum[PW-1:0];
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = CW'(WORD_WIDTH - 1);
               ovf_in   = lane_x.ovf | lane_y.ovf;
            end
         end
         M_ROOT: begin
            rad_in = rad_ff << 2;
            cnt_in = cnt_ff - 1'b1;
            if (rem_try >= root_try) begin
               rem_in  = rem_diff[RW-1:0];
               root_in = {root_ff[WORD_WIDTH-2:0], 1'b1};
            end else begin
               rem_in  = rem_try[RW-1:0];
               root_in = {root_ff[WORD_WIDTH-2:0], 1'b0};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         ovf_ff   <= ovf_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign speed       = root_ff;
   assign status.done = (state_ff == M_DONE);
   assign status.ovf  = ovf_ff;

endmodule

`default_nettype wire

### rtl/verlet_body_integrator.sv
// Multiplier: each lane's shift-add multiplier stops when its multiplier bits
//   run out, so small dt and pixel_scale values finish sooner.
// Throughput: one step at a time; the next input is taken the cycle after the
//   result enters the output register. Set by the lane multiplier and the root.
// Reset: synchronous; state cleared, registers back to dt = 1.0, scale = 1.0.
// ----------------------------------------------------------------------------
// verlet_body_integrator: 2-D position-Verlet integrator, one body
// Two axis lanes run the velocity and position update side by side; the
// merger forms the speed. Config registers and an output register live here.
// ----------------------------------------------------------------------------
`default_nettype none

module verlet_body_integrator
   import vbi_pkg::*;
#(
   parameter int WORD_WIDTH = 48,
   parameter int FRAC_BITS  = 16
)
(
   input  logic                              clock,
   input  logic                              reset,
   // input channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [WORD_WIDTH-1:0]      req_accel_x,
   input  logic signed [WORD_WIDTH-1:0]      req_accel_y,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [WORD_WIDTH-1:0]      rsp_new_pos_x,
   output logic signed [WORD_WIDTH-1:0]      rsp_new_pos_y,
   output logic signed [SCREEN_WIDTH-1:0]    rsp_screen_x,
   output logic signed [SCREEN_WIDTH-1:0]    rsp_screen_y,
   output logic        [WORD_WIDTH-1:0]      rsp_speed,
   output logic                              rsp_overflow,
   // configuration write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic        [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic        [WORD_WIDTH-1:0]      csr_data
);

   localparam logic [STEP_WIDTH-1:0] DT_RESET    = STEP_WIDTH'(1) << FRAC_BITS;
   localparam logic [STEP_WIDTH-1:0] SCALE_RESET = STEP_WIDTH'(1) << SCALE_FRAC;

   // Configuration registers
   logic [STEP_WIDTH-1:0]        time_step_ff, time_step_in;
   logic [STEP_WIDTH-1:0]        pixel_scale_ff, pixel_scale_in;
   logic signed [WORD_WIDTH-1:0] spx_ff, spx_in;
   logic signed [WORD_WIDTH-1:0] spy_ff, spy_in;
   logic signed [WORD_WIDTH-1:0] svx_ff, svx_in;
   logic signed [WORD_WIDTH-1:0] svy_ff, svy_in;

   // Control
   logic busy_ff, busy_in;
   logic first_ff, first_in;
   logic rsp_valid_ff, rsp_valid_in;

   // Output register
   logic signed [WORD_WIDTH-1:0]   pos_x_ff, pos_y_ff;
   logic signed [SCREEN_WIDTH-1:0] scr_x_ff, scr_y_ff;
   logic [WORD_WIDTH-1:0]          speed_ff;
   logic                           ovf_ff;

   // Lane and merger connections
   lane_ctrl_type                  lane_ctrl;
   lane_status_type                lx_status, ly_status;
   merge_status_type               m_status;
   logic                           lane_ack;
   logic signed [WORD_WIDTH-1:0]   lx_pos, ly_pos;
   logic signed [SCREEN_WIDTH-1:0] lx_scr, ly_scr;
   logic [2*WORD_WIDTH-1:0]        lx_vsq, ly_vsq;
   logic [WORD_WIDTH-1:0]          m_speed;

   logic req_xfer;
   logic out_free;
   logic out_load;

   assign req_ready = !busy_ff;
   assign req_xfer  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign out_load  = m_status.done && out_free;

   assign lane_ctrl.start = req_xfer;
   assign lane_ctrl.seed  = first_ff;

   // Configuration writes
   always_comb begin
      time_step_in   = time_step_ff;
      pixel_scale_in = pixel_scale_ff;
      spx_in         = spx_ff;
      spy_in         = spy_ff;
      svx_in         = svx_ff;
      svy_in         = svy_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TIME_STEP:   time_step_in   = csr_data[STEP_WIDTH-1:0];
            CSR_START_POS_X: spx_in         = $signed(csr_data);
            CSR_START_POS_Y: spy_in         = $signed(csr_data);
            CSR_START_VEL_X: svx_in         = $signed(csr_data);
            CSR_START_VEL_Y: svy_in         = $signed(csr_data);
            CSR_PIXEL_SCALE: pixel_scale_in = csr_data[STEP_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   // Step control and output register handshake
   always_comb begin
      busy_in      = busy_ff;
      first_in     = first_ff;
      rsp_valid_in = rsp_valid_ff;
      if (req_xfer) begin
         busy_in  = 1'b1;
         first_in = 1'b0;
      end else if (out_load) begin
         busy_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff   <= DT_RESET;
         pixel_scale_ff <= SCALE_RESET;
         spx_ff         <= '0;
         spy_ff         <= '0;
         svx_ff         <= '0;
         svy_ff         <= '0;
         busy_ff        <= 1'b0;
         first_ff       <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         time_step_ff   <= time_step_in;
         pixel_scale_ff <= pixel_scale_in;
         spx_ff         <= spx_in;
         spy_ff         <= spy_in;
         svx_ff         <= svx_in;
         svy_ff         <= svy_in;
         busy_ff        <= busy_in;
         first_ff       <= first_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      if (out_load) begin
         pos_x_ff <= lx_pos;
         pos_y_ff <= ly_pos;
         scr_x_ff <= lx_scr;
         scr_y_ff <= ly_scr;
         speed_ff <= m_speed;
         ovf_ff   <= m_status.ovf;
      end
   end

   // Axis lanes
   vbi_lane #(
      .WORD_WIDTH (WORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_lane_x (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (lane_ctrl),
      .ack         (lane_ack),
      .acc         (req_accel_x),
      .start_pos   (spx_ff),
      .start_vel   (svx_ff),
      .time_step   (time_step_ff),
      .pixel_scale (pixel_scale_ff),
      .pos         (lx_pos),
      .screen      (lx_scr),
      .vsq         (lx_vsq),
      .status      (lx_status)
   );

   vbi_lane #(
      .WORD_WIDTH (WORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_lane_y (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (lane_ctrl),
      .ack         (lane_ack),
      .acc         (req_accel_y),
      .start_pos   (spy_ff),
      .start_vel   (svy_ff),
      .time_step   (time_step_ff),
      .pixel_scale (pixel_scale_ff),
      .pos         (ly_pos),
      .screen      (ly_scr),
      .vsq         (ly_vsq),
      .status      (ly_status)
   );

   // Speed and flag merge
   vbi_merge #(
      .WORD_WIDTH (WORD_WIDTH)
   ) u_merge (
      .clock    (clock),
      .reset    (reset),
      .lane_x   (lx_status),
      .lane_y   (ly_status),
      .vsq_x    (lx_vsq),
      .vsq_y    (ly_vsq),
      .out_free (out_free),
      .lane_ack (lane_ack),
      .speed    (m_speed),
      .status   (m_status)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_new_pos_x = pos_x_ff;
   assign rsp_new_pos_y = pos_y_ff;
   assign rsp_screen_x  = scr_x_ff;
   assign rsp_screen_y  = scr_y_ff;
   assign rsp_speed     = speed_ff;
   assign rsp_overflow  = ovf_ff;

   // Lanes and merger only report finished work inside a step
   a_lane_busy: assert property (@(posedge clock) disable iff (reset)
      (lx_status.done || ly_status.done) |-> busy_ff)
      else $error("lane finished outside a step");

   a_merge_busy: assert property (@(posedge clock) disable iff (reset)
      m_status.done |-> busy_ff)
      else $error("merger finished outside a step");

   // A new step never starts while the previous one is still in flight
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> (!lx_status.done && !ly_status.done && !m_status.done))
      else $error("input transfer while a step is in flight");

   // The output register fills only from a finished merge
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(m_status.done))
      else $error("result appeared without a finished step");

   // The seed flag clears only on the first input transfer
   a_seed_once: assert property (@(posedge clock) disable iff (reset)
      $fell(first_ff) |-> $past(req_xfer))
      else $error("seed flag cleared without a transfer");

endmodule

`default_nettype wire
